// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the warp RTL.
// Each macro expands to one labeled concurrent assertion with reset masking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is low
`define AST_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is low
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/pwbm_pkg.sv =====
// Shared constants, types and multiply helpers for the plane warp backward map.
// Used by pwbm_div and plane_warp_backward_map; no dependencies.
`timescale 1ns / 1ps
package pwbm_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 32;
    localparam int QBITS      = 32;
    localparam int CFG_W      = 64;
    localparam int NUM_REGS   = 5;
    localparam int IDX_W      = 3;

    // u * recip, exact
    localparam int SU_W   = COORD_BITS + 32;
    localparam int SPLIT  = SU_W / 2;
    localparam int PL_W   = COEF_W + SPLIT + 1;
    localparam int PH_W   = COEF_W + SU_W - SPLIT;
    localparam int PROD_W = COEF_W + SU_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int DIV_W  = NUM_W + QBITS;
    localparam int DIV_LAT = QBITS + 2;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_01  = 3'd0,
        REG_COEF_23  = 3'd1,
        REG_COEF_45  = 3'd2,
        REG_COEF_67  = 3'd3,
        REG_COEF8_RS = 3'd4
    } t_reg_idx;

    localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536
    };

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             neg;
    } t_div_req;

    typedef struct packed {
        logic [QBITS-1:0] q;
        logic             sat;
    } t_div_rsp;

    // Coefficient times the unsigned low half of a scaled coordinate
    function automatic logic signed [PL_W-1:0] mul_lo(logic signed [COEF_W-1:0] m,
                                                      logic [SPLIT-1:0] lo);
        logic signed [SPLIT:0]  l;
        logic signed [PL_W-1:0] p;
        l = signed'({1'b0, lo});
        p = m * l;
        return p;
    endfunction

    // Coefficient times the signed high half of a scaled coordinate
    function automatic logic signed [PH_W-1:0] mul_hi(logic signed [COEF_W-1:0] m,
                                                      logic signed [SU_W-SPLIT-1:0] hi);
        logic signed [PH_W-1:0] p;
        p = m * hi;
        return p;
    endfunction

endpackage

// ===== hdl/pwbm_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, saturating to 32 bits.
// Depends on pwbm_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
module pwbm_div (
    input  logic              i_clk,
    input  logic              i_en,
    input  pwbm_pkg::t_div_req i_req,
    output pwbm_pkg::t_div_rsp o_rsp
);
    import pwbm_pkg::*;

    logic [NUM_W-1:0] r_rem [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic [MAG_W-1:0] r_den [0:QBITS];
    logic             r_neg [0:QBITS];
    logic             r_ovf [0:QBITS];
    t_div_rsp         r_rsp;
    t_div_rsp         n_rsp;

    // Flag quotients of 2^32 or more up front
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_req.num;
            r_q[0]   <= '0;
            r_den[0] <= i_req.den;
            r_neg[0] <= i_req.neg;
            r_ovf[0] <= DIV_W'(i_req.num) >= (DIV_W'(i_req.den) << QBITS);
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar i = 1; i <= QBITS; i++) begin : g_stage
        logic [DIV_W-1:0] w_dsh;
        logic             w_ge;
        assign w_dsh = DIV_W'(r_den[i-1]) << (QBITS - i);
        assign w_ge  = DIV_W'(r_rem[i-1]) >= w_dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= w_ge ? NUM_W'(DIV_W'(r_rem[i-1]) - w_dsh) : r_rem[i-1];
                r_q[i]   <= {r_q[i-1][QBITS-2:0], w_ge};
                r_den[i] <= r_den[i-1];
                r_neg[i] <= r_neg[i-1];
                r_ovf[i] <= r_ovf[i-1];
            end
        end
    end

    // Apply sign and saturate
    always_comb begin
        n_rsp.sat = 1'b0;
        n_rsp.q   = r_q[QBITS];
        if (r_neg[QBITS]) begin
            if (r_ovf[QBITS] || r_q[QBITS] > {1'b1, {(QBITS-1){1'b0}}}) begin
                n_rsp.sat = 1'b1;
                n_rsp.q   = {1'b1, {(QBITS-1){1'b0}}};
            end else begin
                n_rsp.q = QBITS'(0) - r_q[QBITS];
            end
        end else if (r_ovf[QBITS] || r_q[QBITS][QBITS-1]) begin
            n_rsp.sat = 1'b1;
            n_rsp.q   = {1'b0, {(QBITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hdl/plane_warp_backward_map.sv =====
// Top level of the plane warp backward map: config registers, matrix pipeline.
// Depends on pwbm_pkg, pwbm_div and assert_macros.svh.
//
//   channel   valid         ready        payload
//   input     i_valid       o_ready      i_dest_u, i_dest_v
//   result    o_valid       i_ready      o_src_x, o_src_y, o_invalid
//   config    i_cfg_valid   o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request enters per clock unless the pipeline holds; there are five stages of scaling,
// split multiplies, product assembly, row sums and sign removal, then 34
// stages of the bit-per-stage divider and its output register.
// The whole pipeline holds while a result waits and i_ready is low.
// Reset clears valid bits and loads the register reset values; config is
// always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plane_warp_backward_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pwbm_pkg::COORD_BITS-1:0] i_dest_u,
    input  logic signed [pwbm_pkg::COORD_BITS-1:0] i_dest_v,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pwbm_pkg::QBITS-1:0]    o_src_x,
    output logic signed [pwbm_pkg::QBITS-1:0]    o_src_y,
    output logic                                 o_invalid,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pwbm_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [pwbm_pkg::CFG_W-1:0]           i_cfg_data
);
    import pwbm_pkg::*;

    logic [CFG_W-1:0] r_cfg [0:NUM_REGS-1];
    logic             w_adv;

    // Config write port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= REG_RESET[k];
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COEF_01:  r_cfg[REG_COEF_01]  <= i_cfg_data;
                REG_COEF_23:  r_cfg[REG_COEF_23]  <= i_cfg_data;
                REG_COEF_45:  r_cfg[REG_COEF_45]  <= i_cfg_data;
                REG_COEF_67:  r_cfg[REG_COEF_67]  <= i_cfg_data;
                REG_COEF8_RS: r_cfg[REG_COEF8_RS] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Matrix entries: order m00 m01 m02 m10 m11 m12 m20 m21 m22
    logic signed [COEF_W-1:0] w_m [0:8];
    logic [31:0]              w_recip;
    for (genvar k = 0; k < 4; k++) begin : g_coef
        assign w_m[2*k]   = signed'(r_cfg[k][COEF_W-1:0]);
        assign w_m[2*k+1] = signed'(r_cfg[k][CFG_W-1:COEF_W]);
    end
    assign w_m[8]  = signed'(r_cfg[REG_COEF8_RS][COEF_W-1:0]);
    assign w_recip = r_cfg[REG_COEF8_RS][CFG_W-1:COEF_W];

    // Pipeline advances unless a result is waiting
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    logic r_vld [0:4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < 5; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stage 1: scale both coordinates by the reciprocal
    logic signed [32:0]     w_recip_s;
    logic signed [SU_W:0]   w_pu;
    logic signed [SU_W:0]   w_pv;
    logic signed [SU_W-1:0] r1_su;
    logic signed [SU_W-1:0] r1_sv;
    assign w_recip_s = signed'({1'b0, w_recip});
    assign w_pu      = i_dest_u * w_recip_s;
    assign w_pv      = i_dest_v * w_recip_s;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_su <= SU_W'(w_pu);
            r1_sv <= SU_W'(w_pv);
        end
    end

    // Stage 2: split partial products (rows x, y, z; u then v)
    logic signed [PL_W-1:0] r2_lo [0:5];
    logic signed [PH_W-1:0] r2_hi [0:5];
    for (genvar r = 0; r < 3; r++) begin : g_part
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r2_lo[2*r]   <= mul_lo(w_m[3*r],   r1_su[SPLIT-1:0]);
                r2_hi[2*r]   <= mul_hi(w_m[3*r],   r1_su[SU_W-1:SPLIT]);
                r2_lo[2*r+1] <= mul_lo(w_m[3*r+1], r1_sv[SPLIT-1:0]);
                r2_hi[2*r+1] <= mul_hi(w_m[3*r+1], r1_sv[SU_W-1:SPLIT]);
            end
        end
    end

    // Stage 3: assemble full products
    logic signed [PROD_W-1:0] r3_p [0:5];
    for (genvar k = 0; k < 6; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r3_p[k] <= (PROD_W'(r2_hi[k]) <<< SPLIT) + PROD_W'(r2_lo[k]);
            end
        end
    end

    // Stage 4: row sums with the constant column aligned to 48 fraction bits
    logic signed [SUM_W-1:0] r4_s [0:2];
    for (genvar r = 0; r < 3; r++) begin : g_sum
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r4_s[r] <= SUM_W'(r3_p[2*r]) + SUM_W'(r3_p[2*r+1])
                         + (SUM_W'(w_m[3*r+2]) <<< 32);
            end
        end
    end

    // Stage 5: strip signs, flag a zero denominator
    logic [MAG_W-1:0] r5_mag [0:2];
    logic             r5_sgn [0:2];
    logic             r5_zero;
    for (genvar r = 0; r < 3; r++) begin : g_abs
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r5_mag[r] <= MAG_W'(r4_s[r][SUM_W-1] ? -r4_s[r] : r4_s[r]);
                r5_sgn[r] <= r4_s[r][SUM_W-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_zero <= (r4_s[2] == '0);
        end
    end

    // Dividers for both coordinates
    t_div_req w_req_x;
    t_div_req w_req_y;
    t_div_rsp w_rsp_x;
    t_div_rsp w_rsp_y;
    assign w_req_x = '{num: {r5_mag[0], {FRAC_BITS{1'b0}}}, den: r5_mag[2],
                       neg: r5_sgn[0] ^ r5_sgn[2]};
    assign w_req_y = '{num: {r5_mag[1], {FRAC_BITS{1'b0}}}, den: r5_mag[2],
                       neg: r5_sgn[1] ^ r5_sgn[2]};

    pwbm_div u_div_x (.i_clk(i_clk), .i_en(w_adv), .i_req(w_req_x), .o_rsp(w_rsp_x));
    pwbm_div u_div_y (.i_clk(i_clk), .i_en(w_adv), .i_req(w_req_y), .o_rsp(w_rsp_y));

    // Carry valid and the zero flag alongside the dividers
    logic r_dvld  [0:DIV_LAT-1];
    logic r_dzero [0:DIV_LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_dvld[0] <= r_vld[4];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dvld[k] <= r_dvld[k-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dzero[0] <= r5_zero;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dzero[k] <= r_dzero[k-1];
            end
        end
    end

    // Drive results; a zero denominator forces zeros
    assign o_valid   = r_dvld[DIV_LAT-1];
    assign o_src_x   = r_dzero[DIV_LAT-1] ? '0 : signed'(w_rsp_x.q);
    assign o_src_y   = r_dzero[DIV_LAT-1] ? '0 : signed'(w_rsp_y.q);
    assign o_invalid = r_dzero[DIV_LAT-1] || w_rsp_x.sat || w_rsp_y.sat;

    `AST_SAME(a_zero_den, i_clk, i_rst_n, o_valid && r_dzero[DIV_LAT-1], o_invalid && o_src_x == '0 && o_src_y == '0)
    `AST_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_vld[0])
    `AST_SAME(a_empty_flows, i_clk, i_rst_n, !o_valid, o_ready)

endmodule

// ===== dv/plane_warp_backward_map_tb.sv =====
// Testbench for plane_warp_backward_map: random and directed pixel requests,
// predicted source coordinates checked in order. Depends on pwbm_pkg and plane_warp_backward_map.
`timescale 1ns / 1ps
module plane_warp_backward_map_tb;
    import pwbm_pkg::*;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
    } t_pix;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        bad;
    } t_map;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic signed [15:0] i_dest_u = '0;
    logic signed [15:0] i_dest_v = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_src_x;
    logic signed [31:0] o_src_y;
    logic        o_invalid;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic [63:0] coef_regs [NUM_REGS];
    t_pix        pix_pending [$];
    t_map        map_expected [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    bit          drv_quiet = 0;
    bit          mon_quiet = 0;

    plane_warp_backward_map u_top (.*);

    always #5 i_clk = ~i_clk;

    // Signed quotient with truncation toward zero and 32-bit saturation
    function automatic logic [31:0] sat_div(logic signed [127:0] num,
                                            logic signed [127:0] den, inout bit sat);
        logic signed [127:0] q;
        q = num / den;
        if (q > 128'sd2147483647) begin
            sat = 1;
            return 32'h7fffffff;
        end
        if (q < -128'sd2147483648) begin
            sat = 1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    // Project one destination pixel through the configured matrix
    function automatic t_map warp_pixel(t_pix p);
        logic signed [127:0] m [9];
        logic signed [127:0] su, sv, rx, ry, rz, rs;
        t_map r;
        bit sat;
        for (int k = 0; k < 4; k++) begin
            m[2*k]   = 128'(signed'(coef_regs[k][31:0]));
            m[2*k+1] = 128'(signed'(coef_regs[k][63:32]));
        end
        m[8] = 128'(signed'(coef_regs[4][31:0]));
        rs = 128'(coef_regs[4][63:32]);
        su = 128'(signed'(p.u)) * rs;
        sv = 128'(signed'(p.v)) * rs;
        rx = m[0] * su + m[1] * sv + (m[2] <<< 32);
        ry = m[3] * su + m[4] * sv + (m[5] <<< 32);
        rz = m[6] * su + m[7] * sv + (m[8] <<< 32);
        sat = 0;
        if (rz == 0) begin
            r.x = '0;
            r.y = '0;
            r.bad = 1'b1;
        end else begin
            r.x = sat_div(rx <<< FRAC_BITS, rz, sat);
            r.y = sat_div(ry <<< FRAC_BITS, rz, sat);
            r.bad = sat;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_q16(int mode);
        case (mode)
            0: return 32'h00010000;
            1: return 32'(signed'($urandom_range(0, 8192)) - 4096);
            2: return 32'(signed'($urandom_range(0, 262144)) - 131072);
            3: return 32'h80000000;
            4: return 32'h7fffffff;
            default: return $urandom;
        endcase
    endfunction

    // Driver: present queued pixels, hold until accepted
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (pix_pending.size() > 0 && (drv_quiet || $urandom_range(0, 99) >= 18)) begin
                    t_pix p;
                    p = pix_pending.pop_front();
                    map_expected = {map_expected, warp_pixel(p)};
                    i_valid <= 1'b1;
                    i_dest_u <= p.u;
                    i_dest_v <= p.v;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= mon_quiet || $urandom_range(0, 99) >= 18;
        end
    end

    // Monitor: compare each returned result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (map_expected.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result x=%h y=%h inv=%b", o_src_x, o_src_y, o_invalid);
            end else begin
                t_map e;
                e = map_expected.pop_front();
                if (e.x !== o_src_x || e.y !== o_src_y || e.bad !== o_invalid) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch exp x=%h y=%h inv=%b got x=%h y=%h inv=%b",
                                 e.x, e.y, e.bad, o_src_x, o_src_y, o_invalid);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycle_cnt > 400000) begin
            $display("plane_warp_backward_map_tb: done, errors");
            $finish;
        end
    end

    // Write one register, then leave the port idle
    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        coef_regs[idx] = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the pipeline to empty before touching registers
    task automatic drain;
        while (pix_pending.size() > 0 || map_expected.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic queue_pixel(logic [15:0] u, logic [15:0] v);
        t_pix p;
        p.u = u;
        p.v = v;
        pix_pending = {pix_pending, p};
    endtask

    task automatic load_matrix(int mode, logic [31:0] recip);
        write_reg(REG_COEF_01, {rand_q16(mode), rand_q16(mode)});
        write_reg(REG_COEF_23, {rand_q16(mode), rand_q16(mode)});
        write_reg(REG_COEF_45, {rand_q16(mode), rand_q16(mode)});
        write_reg(REG_COEF_67, {rand_q16(mode), rand_q16(mode)});
        write_reg(REG_COEF8_RS, {recip, rand_q16(mode == 0 ? 0 : mode)});
    endtask

    initial begin
        for (int k = 0; k < NUM_REGS; k++) coef_regs[k] = REG_RESET[k];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: zero scale makes every denominator m22 alone
        queue_pixel(16'h0000, 16'h0000);
        queue_pixel(16'h7fff, 16'h8000);
        drain();

        // Identity with unit scale, corner coordinates
        write_reg(REG_COEF8_RS, {32'hffffffff, 32'h00010000});
        queue_pixel(16'h7fff, 16'h7fff);
        queue_pixel(16'h8000, 16'h8000);
        queue_pixel(16'h0001, 16'hffff);
        queue_pixel(16'h0000, 16'h0000);
        drain();

        // Zero denominator, negative denominator, saturating quotients
        write_reg(REG_COEF_67, 64'h0);
        write_reg(REG_COEF8_RS, {32'h80000000, 32'h0});
        queue_pixel(16'h1234, 16'h8000);
        drain();
        write_reg(REG_COEF8_RS, {32'h80000000, 32'hffff0000});
        queue_pixel(16'h0005, 16'hfffb);
        queue_pixel(16'h7fff, 16'h8000);
        drain();
        write_reg(REG_COEF_01, {32'h7fffffff, 32'h7fffffff});
        write_reg(REG_COEF_23, {32'h80000000, 32'h7fffffff});
        write_reg(REG_COEF8_RS, {32'hffffffff, 32'h00000001});
        queue_pixel(16'h7fff, 16'h7fff);
        queue_pixel(16'h8000, 16'h0001);
        queue_pixel(16'h0000, 16'h0000);
        drain();

        // Random phases across matrix styles and scales
        for (int ph = 0; ph < 15; ph++) begin
            logic [31:0] recip;
            case (ph % 4)
                0: recip = 32'hffffffff;
                1: recip = 32'h0;
                2: recip = $urandom_range(1, 65535);
                default: recip = $urandom;
            endcase
            load_matrix(ph % 6, recip);
            drv_quiet = (ph == 7);
            mon_quiet = (ph == 7);
            for (int n = 0; n < 50; n++) begin
                if (n % 10 == 0)
                    queue_pixel(16'($urandom), 16'($urandom));
                else
                    queue_pixel(16'($urandom_range(0, 2047) - 1024),
                                16'($urandom_range(0, 2047) - 1024));
            end
            drain();
        end

        if (mismatch_cnt == 0)
            $display("plane_warp_backward_map_tb: done, clean");
        else
            $display("plane_warp_backward_map_tb: done, errors");
        $finish;
    end
endmodule
